/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and sizing for the block bitmap allocator: block counts,
// bitmap and summary geometry, status codes and the find-zero result.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // block space
    localparam int GROUPS           = 4;
    localparam int BLOCKS_PER_GROUP = 8192;
    localparam int INDEX_W          = 15;
    localparam int STATUS_W         = 2;
    localparam int TOTAL_BLOCKS     = GROUPS * BLOCKS_PER_GROUP;
    localparam int NAMEABLE         = 1 << INDEX_W;
    localparam int LIMIT_BLOCKS     = (TOTAL_BLOCKS < NAMEABLE) ? TOTAL_BLOCKS : NAMEABLE;

    // bitmap word geometry
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int WORDS     = (LIMIT_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int SUM_WORDS = (WORDS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;

    // stream packing
    localparam int S_DATA_W = ((INDEX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((INDEX_W + STATUS_W + 7) / 8) * 8;

    // request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    // lowest clear bit of a word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } ffz_res_t;

endpackage

`default_nettype wire

/* rtl/bba_find_zero.sv */
// ----------------------------------------------------------------------------
// bba_find_zero
// Shared priority encoder: position of the lowest clear bit of a 32-bit
// word, used in turn on the summary, the group-summary word and the bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_find_zero
    import bba_pkg::*;
(
    input  wire logic [WORD_W-1:0] word,
    output ffz_res_t               res
);

    // scan from the top so the lowest clear bit wins
    always_comb begin
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word[i]) begin
                res.found = 1'b1;
                res.idx   = BIT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/block_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top
// First-free block allocator over a flat used-bitmap with a two-level
// summary of full words, so an allocation needs only two memory reads.
//
//   channel   dir   ports                      contents
//   s_        in    s_tvalid s_tready          tuser: func
//                   s_tdata s_tuser            tdata: block_index
//   m_        out   m_tvalid m_tready m_tdata  tdata: block_index_out, status
//
// Allocate: steps through the summary flops, the group word and the bitmap
// word, all through one shared find-zero encoder. Free: one read of bitmap
// and group word, then write-back. Out-of-range frees and allocations on a
// full bitmap are rejected without a bitmap write; a free of a block
// already free goes read, check, result. After reset a clearing pass writes
// every bitmap word (1024 at the default sizes), with s_tready low.
// A held result stalls only the final state of the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator_top
    import bba_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // [14:0] block_index
    input  wire logic [0:0]          s_tuser,  // [0] func
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata   // [14:0] block_index_out, [16:15] status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_MID,
        S_A_WORD,
        S_FREE,
        S_EARLY
    } state_t;

    // sequencer and result registers
    state_t                state_reg,      state_next;
    logic [WORD_AW-1:0]    clr_cnt_reg,    clr_cnt_next;
    logic [SUM_WORDS-1:0]  l2_reg,         l2_next;
    logic [INDEX_W-1:0]    blk_reg,        blk_next;
    logic [SUM_AW-1:0]     sum_idx_reg,    sum_idx_next;
    logic [BIT_W-1:0]      j_reg,          j_next;
    logic [WORD_AW-1:0]    w_reg,          w_next;
    status_t               early_st_reg,   early_st_next;
    logic                  m_valid_reg,    m_valid_next;
    logic [INDEX_W-1:0]    m_idx_reg,      m_idx_next;
    status_t               m_status_reg,   m_status_next;

    // memories and their ports
    logic [WORD_W-1:0]     bm_mem [WORDS];
    logic [WORD_W-1:0]     l1_mem [SUM_WORDS];
    logic [WORD_W-1:0]     bm_rdata_reg;
    logic [WORD_W-1:0]     l1_rdata_reg;
    logic                  bm_re, bm_we, l1_re, l1_we;
    logic [WORD_AW-1:0]    bm_raddr, bm_waddr;
    logic [SUM_AW-1:0]     l1_raddr, l1_waddr;
    logic [WORD_W-1:0]     bm_wdata, l1_wdata;

    // shared encoder
    logic [WORD_W-1:0]     enc_word;
    ffz_res_t              enc_res;
    logic [WORD_W-1:0]     l2_pad;

    logic                  accept;
    logic                  out_free;
    logic [INDEX_W-1:0]    in_blk;
    logic [SUM_AW+BIT_W-1:0] mid_w;
    logic [INDEX_W-1:0]    alloc_idx;
    logic [WORD_W-1:0]     bm_set, l1_set;
    logic [WORD_AW-1:0]    free_w;
    logic [SUM_AW-1:0]     free_l1a;
    logic [BIT_W-1:0]      free_l1b;

    bba_find_zero u_find_zero (
        .word (enc_word),
        .res  (enc_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign in_blk   = s_tdata[INDEX_W-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_status_reg, m_idx_reg});

    // missing summary entries read as full so they are never chosen
    always_comb begin
        l2_pad                  = '1;
        l2_pad[SUM_WORDS-1:0]   = l2_reg;
    end

    // encoder input follows the step in progress
    always_comb begin
        case (state_reg)
            S_A_MID:  enc_word = l1_rdata_reg;
            S_A_WORD: enc_word = bm_rdata_reg;
            default:  enc_word = l2_pad;
        endcase
    end

    // address pieces of the current request
    assign mid_w     = {sum_idx_reg, enc_res.idx};
    assign alloc_idx = INDEX_W'({w_reg, enc_res.idx});
    assign bm_set    = bm_rdata_reg | (WORD_W'(1) << enc_res.idx);
    assign l1_set    = l1_rdata_reg | (WORD_W'(1) << j_reg);
    assign free_w    = blk_reg[BIT_W +: WORD_AW];
    assign free_l1a  = blk_reg[2*BIT_W +: SUM_AW];
    assign free_l1b  = blk_reg[BIT_W +: BIT_W];

    // next-state and memory control
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        l2_next       = l2_reg;
        blk_next      = blk_reg;
        sum_idx_next  = sum_idx_reg;
        j_next        = j_reg;
        w_next        = w_reg;
        early_st_next = early_st_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_idx_next    = m_idx_reg;
        m_status_next = m_status_reg;

        bm_re    = 1'b0;
        bm_we    = 1'b0;
        l1_re    = 1'b0;
        l1_we    = 1'b0;
        bm_raddr = in_blk[BIT_W +: WORD_AW];
        l1_raddr = in_blk[2*BIT_W +: SUM_AW];
        bm_waddr = free_w;
        l1_waddr = free_l1a;
        bm_wdata = '0;
        l1_wdata = '0;

        unique case (state_reg)
            // clearing pass over both memories
            S_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = clr_cnt_reg;
                if ((WORD_AW + 1)'(clr_cnt_reg) < (WORD_AW + 1)'(SUM_WORDS)) begin
                    l1_we    = 1'b1;
                    l1_waddr = clr_cnt_reg[SUM_AW-1:0];
                end
                if ((WORD_AW + 1)'(clr_cnt_reg) == (WORD_AW + 1)'(WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            // take a request, start the first lookup
            S_IDLE: begin
                if (accept) begin
                    blk_next = in_blk;
                    if (s_tuser[0] == FUNC_FREE) begin
                        if ((INDEX_W + 1)'(in_blk) >= (INDEX_W + 1)'(LIMIT_BLOCKS)) begin
                            early_st_next = ST_RANGE;
                            state_next    = S_EARLY;
                        end else begin
                            bm_re      = 1'b1;
                            l1_re      = 1'b1;
                            state_next = S_FREE;
                        end
                    end else if (!enc_res.found) begin
                        blk_next      = '0;
                        early_st_next = ST_FULL;
                        state_next    = S_EARLY;
                    end else begin
                        sum_idx_next = enc_res.idx[SUM_AW-1:0];
                        l1_re        = 1'b1;
                        l1_raddr     = enc_res.idx[SUM_AW-1:0];
                        state_next   = S_A_MID;
                    end
                end
            end

            // pick the first non-full bitmap word of the group
            S_A_MID: begin
                if (!enc_res.found ||
                    (SUM_AW + BIT_W + 1)'(mid_w) >= (SUM_AW + BIT_W + 1)'(WORDS)) begin
                    blk_next      = '0;
                    early_st_next = ST_FULL;
                    state_next    = S_EARLY;
                end else begin
                    j_next     = enc_res.idx;
                    w_next     = mid_w[WORD_AW-1:0];
                    bm_re      = 1'b1;
                    bm_raddr   = mid_w[WORD_AW-1:0];
                    state_next = S_A_WORD;
                end
            end

            // claim the lowest free bit and update the summaries
            S_A_WORD: begin
                if (!enc_res.found ||
                    (INDEX_W + 1)'(alloc_idx) >= (INDEX_W + 1)'(LIMIT_BLOCKS)) begin
                    blk_next      = '0;
                    early_st_next = ST_FULL;
                    state_next    = S_EARLY;
                end else if (out_free) begin
                    bm_we    = 1'b1;
                    bm_waddr = w_reg;
                    bm_wdata = bm_set;
                    if (&bm_set) begin
                        l1_we    = 1'b1;
                        l1_waddr = sum_idx_reg;
                        l1_wdata = l1_set;
                        if (&l1_set) begin
                            l2_next[sum_idx_reg] = 1'b1;
                        end
                    end
                    m_valid_next  = 1'b1;
                    m_idx_next    = alloc_idx;
                    m_status_next = ST_OK;
                    state_next    = S_IDLE;
                end
            end

            // release a used block
            S_FREE: begin
                if (!bm_rdata_reg[blk_reg[BIT_W-1:0]]) begin
                    early_st_next = ST_NOT_USED;
                    state_next    = S_EARLY;
                end else if (out_free) begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata_reg & ~(WORD_W'(1) << blk_reg[BIT_W-1:0]);
                    l1_we    = 1'b1;
                    l1_wdata = l1_rdata_reg & ~(WORD_W'(1) << free_l1b);
                    l2_next[free_l1a] = 1'b0;
                    m_valid_next  = 1'b1;
                    m_idx_next    = blk_reg;
                    m_status_next = ST_OK;
                    state_next    = S_IDLE;
                end
            end

            // rejected or full request, nothing changes
            S_EARLY: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_idx_next    = blk_reg;
                    m_status_next = early_st_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            l2_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            l2_reg      <= l2_next;
            m_valid_reg <= m_valid_next;
        end
        blk_reg      <= blk_next;
        sum_idx_reg  <= sum_idx_next;
        j_reg        <= j_next;
        w_reg        <= w_next;
        early_st_reg <= early_st_next;
        m_idx_reg    <= m_idx_next;
        m_status_reg <= m_status_next;
    end

    // used bitmap, one port each way
    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            bm_rdata_reg <= bm_mem[bm_raddr];
        end
    end

    // full-word summary per group of words
    always_ff @(posedge aclk) begin
        if (l1_we) begin
            l1_mem[l1_waddr] <= l1_wdata;
        end
        if (l1_re) begin
            l1_rdata_reg <= l1_mem[l1_raddr];
        end
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block bitmap allocator. Requests go in through
// the s_ stream in random bursts, and results are taken from the m_ stream
// under a random stall pattern. A bitmap predictor inside the bench works
// out each result as its request is accepted. Every result is checked in
// order against that prediction. The run covers directed corner cases,
// random alloc/free traffic, a long output hold-off, reuse of freed holes
// across a word boundary, and traffic under heavy idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import bba_pkg::*;

    // predicted result of one request
    typedef struct packed {
        logic [INDEX_W-1:0] block_no;
        status_t            status;
    } alloc_result_t;

    localparam int LONG_HOLD = 300;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // predictor state
    logic [WORD_W-1:0] used_words [WORDS];
    int                lowest_open_word;

    alloc_result_t pending_results [$];
    int            held_blocks [$];
    int            mismatches = 0;

    // sender and receiver pacing
    int burst_left  = 0;
    int gap_max     = 4;
    int stall_max   = 3;
    int hold_asked  = 0;
    int hold_taken  = 0;
    int hold_left   = 0;
    int ready_left  = 0;
    bit ready_phase = 1'b1;

    block_bitmap_allocator_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [14:0] block_index
        .s_tuser  (s_tuser),   // [0] func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [14:0] block_index_out, [16:15] status
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // bitmap cleared, every block free
    function automatic void bitmap_clear();
        for (int w = 0; w < WORDS; w++) used_words[w] = '0;
        lowest_open_word = 0;
    endfunction

    // apply one request to the predicted bitmap and return its result
    function automatic alloc_result_t bitmap_apply(input logic fn,
                                                   input logic [INDEX_W-1:0] blk);
        alloc_result_t res;
        int            w;
        int            b;
        int            flat;
        bit            stop;
        res.block_no = '0;
        res.status   = ST_FULL;
        if (fn == FUNC_ALLOC) begin
            // words below the hint are known to be full
            w    = lowest_open_word;
            stop = 1'b0;
            while (!stop && w < WORDS) begin
                if (~used_words[w] != '0) begin
                    b = 0;
                    while (used_words[w][b]) b++;
                    flat = w * WORD_W + b;
                    if (flat < LIMIT_BLOCKS) begin
                        used_words[w][b] = 1'b1;
                        res.block_no     = INDEX_W'(flat);
                        res.status       = ST_OK;
                    end
                    stop = 1'b1;
                end else begin
                    w++;
                end
            end
            lowest_open_word = w;
        end else begin
            res.block_no = blk;
            if (int'(blk) >= LIMIT_BLOCKS) begin
                res.status = ST_RANGE;
            end else if (!used_words[blk >> BIT_W][blk[BIT_W-1:0]]) begin
                res.status = ST_NOT_USED;
            end else begin
                used_words[blk >> BIT_W][blk[BIT_W-1:0]] = 1'b0;
                res.status = ST_OK;
                if (int'(blk >> BIT_W) < lowest_open_word)
                    lowest_open_word = int'(blk >> BIT_W);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // offer one request, wait for acceptance, then record its expected result
    task automatic send_request(input logic fn, input logic [INDEX_W-1:0] blk);
        int            gap;
        alloc_result_t want;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(blk);
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        want = bitmap_apply(fn, blk);
        pending_results.push_back(want);
        if (fn == FUNC_ALLOC && want.status == ST_OK)
            held_blocks.push_back(int'(want.block_no));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // one random request: allocate, free a held block, or free any number
    task automatic random_request();
        int pick;
        int k;
        int blk;
        pick = $urandom_range(0, 99);
        if (pick < 50 || (pick < 80 && held_blocks.size() == 0)) begin
            send_request(FUNC_ALLOC, INDEX_W'($urandom));
        end else if (pick < 80) begin
            k   = $urandom_range(0, held_blocks.size() - 1);
            blk = held_blocks[k];
            held_blocks.delete(k);
            send_request(FUNC_FREE, INDEX_W'(blk));
        end else begin
            blk = (pick < 90) ? $urandom_range(0, 127) : $urandom_range(0, NAMEABLE - 1);
            send_request(FUNC_FREE, INDEX_W'(blk));
        end
    endtask

    // corner cases on a fresh bitmap
    task automatic test_directed();
        gap_max   = 2;
        stall_max = 2;
        send_request(FUNC_FREE, '0);
        send_request(FUNC_FREE, '1);
        send_request(FUNC_FREE, 15'h5555);
        send_request(FUNC_FREE, 15'h2aaa);
        send_request(FUNC_ALLOC, '1);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, 15'h5555);
        send_request(FUNC_ALLOC, 15'h2aaa);
        send_request(FUNC_FREE, 15'd1);
        send_request(FUNC_FREE, 15'd1);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 15'd3);
        send_request(FUNC_FREE, 15'd0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        // out of range only exists when the block count is below the index space
        if (LIMIT_BLOCKS < NAMEABLE) begin
            send_request(FUNC_FREE, INDEX_W'(LIMIT_BLOCKS));
            send_request(FUNC_FREE, '1);
        end
        drain_results();
    endtask

    // random traffic: idling, then a stretch with none, then heavy idling
    task automatic test_random_mix();
        gap_max   = 4;
        stall_max = 3;
        repeat (250) random_request();
        gap_max   = 0;
        stall_max = 0;
        repeat (100) random_request();
        gap_max   = 8;
        stall_max = 10;
        repeat (250) random_request();
        drain_results();
    endtask

    // long output hold-off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        gap_max   = 0;
        stall_max = 2;
        hold_asked++;
        repeat (24) random_request();
        drain_results();
    endtask

    // empty the bitmap, fill two whole words, then reuse freed holes
    task automatic test_reuse_holes();
        int blk;
        gap_max   = 1;
        stall_max = 1;
        while (held_blocks.size() != 0) begin
            blk = held_blocks.pop_front();
            send_request(FUNC_FREE, INDEX_W'(blk));
        end
        repeat (2 * WORD_W) send_request(FUNC_ALLOC, INDEX_W'($urandom));
        // holes either side of a word boundary
        send_request(FUNC_FREE, 15'd32);
        send_request(FUNC_FREE, 15'd31);
        send_request(FUNC_FREE, 15'd31);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        drain_results();
    endtask

    // mixed traffic under heavy idling on both sides
    task automatic test_heavy_idle();
        gap_max   = 6;
        stall_max = 8;
        repeat (100) random_request();
        drain_results();
    endtask

    // result receiver: random ready/stall runs, plus a long hold when asked
    always @(negedge aclk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (ready_left == 0) begin
                ready_phase = !ready_phase;
                ready_left  = ready_phase ? $urandom_range(1, 16) : $urandom_range(0, stall_max);
                if (ready_left == 0) begin
                    ready_phase = 1'b1;
                    ready_left  = $urandom_range(1, 16);
                end
            end
            ready_left--;
            m_tready <= ready_phase;
        end
    end

    // result checker
    always @(posedge aclk) begin : check_results
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding, block", -1,
                                int'(m_tdata[INDEX_W-1:0]));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[INDEX_W-1:0] !== want.block_no)
                    report_mismatch("block_index_out", int'(want.block_no),
                                    int'(m_tdata[INDEX_W-1:0]));
                if (m_tdata[INDEX_W +: STATUS_W] !== want.status)
                    report_mismatch("status", int'(want.status),
                                    int'(m_tdata[INDEX_W +: STATUS_W]));
            end
        end
    end

    initial begin
        bitmap_clear();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_mix();
        test_output_backpressure();
        test_reuse_holes();
        test_heavy_idle();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #6000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* block_bitmap_allocator_top.f */
rtl/bba_pkg.sv
rtl/bba_find_zero.sv
rtl/block_bitmap_allocator_top.sv
sim/tb_top.sv
